@@ rtl/core/apt_pkg.sv @@
package apt_pkg;

  localparam int CAM_W  = 6;
  localparam int TIME_W = 32;
  localparam int OP_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_ACTIVITY = 2'd0;
  localparam logic [OP_W-1:0] OP_SWEEP    = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD   = 1'd1;

  localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 32'd60;
  localparam logic [TIME_W-1:0] MAX_PERIOD_RST   = 32'd300;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CAM_W-1:0]  camera_id;
    logic [TIME_W-1:0] now_time;
  } apt_in_t;

  typedef struct packed {
    logic [CAM_W-1:0]  period_camera;
    logic [TIME_W-1:0] period_start;
    logic [TIME_W-1:0] period_end;
    logic              last_of_run;
  } apt_out_t;

  // controller -> datapath
  typedef struct packed {
    logic act_wr;     // write activity transaction into the table
    logic load_run;   // latch sweep/flush context, rewind scan index
    logic step;       // commit evaluation of current entry, advance index
    logic emit_last;  // push pending period out as last of run
  } apt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic close_hit;  // current entry is valid and must be closed
    logic pend_v;     // a closed period waits in the pending register
    logic out_free;   // output register can take a transaction this cycle
    logic idx_last;   // scan index is at the final entry
  } apt_sts_t;

endpackage

@@ rtl/core/apt_ctrl.sv @@
module apt_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [apt_pkg::OP_W-1:0]   in_opcode,
  output logic                       in_stall,
  input  apt_pkg::apt_sts_t          sts,
  output apt_pkg::apt_cmd_t          cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_EV   = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_opcode)
            apt_pkg::OP_ACTIVITY: cmd.act_wr = 1'b1;
            apt_pkg::OP_SWEEP, apt_pkg::OP_FLUSH: begin
              cmd.load_run = 1'b1;
              state_nxt    = ST_RD;
            end
            default: ;
          endcase
        end
      end
      // read data for the current index lands at the end of this cycle
      ST_RD: state_nxt = ST_EV;
      ST_EV: begin
        // hold when a close needs the output register and it is still busy
        if (!(sts.close_hit && sts.pend_v && !sts.out_free)) begin
          cmd.step  = 1'b1;
          state_nxt = sts.idx_last ? ST_FIN : ST_RD;
        end
      end
      ST_FIN: begin
        if (!sts.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/apt_dp.sv @@
module apt_dp #(
  parameter int MAX_CAMERAS = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  apt_pkg::apt_in_t                in_data,
  input  logic                            cfg_valid,
  input  logic [apt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apt_pkg::TIME_W-1:0]      cfg_data,
  input  apt_pkg::apt_cmd_t               cmd,
  output apt_pkg::apt_sts_t               sts,
  input  logic                            out_stall,
  output logic                            out_valid,
  output apt_pkg::apt_out_t               out_data
);

  localparam int AW = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int DW = (TIME_BITS > apt_pkg::TIME_W) ? apt_pkg::TIME_W + 1 : TIME_BITS;
  localparam int TW = apt_pkg::TIME_W;

  // strict compare of (a - b) mod 2^TIME_BITS (2^(TIME_W+1) if TIME_BITS is larger) against a threshold
  function automatic logic diff_gt(input logic [TW-1:0] a, input logic [TW-1:0] b,
                                   input logic [TW-1:0] thr);
    logic [TW:0]   d;
    logic [DW-1:0] dm;
    d  = {1'b0, a} - {1'b0, b};
    dm = d[DW-1:0];
    return (TW+1)'(dm) > {1'b0, thr};
  endfunction

  logic [TW-1:0] start_mem [MAX_CAMERAS];
  logic [TW-1:0] last_mem  [MAX_CAMERAS];
  logic [TW-1:0] start_rd_r, last_rd_r;

  logic [MAX_CAMERAS-1:0] valid_r, valid_nxt;
  logic [TW-1:0] idle_r, maxp_r;

  logic [AW-1:0] idx_r;
  logic          flush_r;
  logic [TW-1:0] now_r;

  logic                      pend_v_r, pend_v_nxt;
  logic [apt_pkg::CAM_W-1:0] pend_cam_r;
  logic [TW-1:0]             pend_start_r, pend_end_r;

  logic              out_valid_r, out_valid_nxt;
  apt_pkg::apt_out_t out_r;

  logic          cam_ok;
  logic [AW-1:0] act_addr;
  logic          act_en;
  logic          close_hit;
  logic          out_free;
  logic          push_mid;

  assign cam_ok   = {1'b0, in_data.camera_id} < (apt_pkg::CAM_W+1)'(MAX_CAMERAS);
  assign act_addr = in_data.camera_id[AW-1:0];
  assign act_en   = cmd.act_wr && cam_ok;

  assign close_hit = valid_r[idx_r] &&
                     (flush_r || diff_gt(now_r, last_rd_r, idle_r) ||
                      diff_gt(last_rd_r, start_rd_r, maxp_r));
  assign out_free  = !out_valid_r || !out_stall;
  assign push_mid  = cmd.step && close_hit && pend_v_r;

  assign sts.close_hit = close_hit;
  assign sts.pend_v    = pend_v_r;
  assign sts.out_free  = out_free;
  assign sts.idx_last  = (idx_r == AW'(MAX_CAMERAS - 1));

  // table memories: one write port, one registered read at the scan index
  always_ff @(posedge clk) begin
    if (act_en) begin
      if (!valid_r[act_addr]) begin
        start_mem[act_addr] <= in_data.now_time;
      end
      last_mem[act_addr] <= in_data.now_time;
    end
    start_rd_r <= start_mem[idx_r];
    last_rd_r  <= last_mem[idx_r];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (act_en) begin
      valid_nxt[act_addr] = 1'b1;
    end
    if (cmd.step && close_hit) begin
      valid_nxt[idx_r] = 1'b0;
    end
  end

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (cmd.step && close_hit) begin
      pend_v_nxt = 1'b1;
    end else if (cmd.emit_last) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (push_mid || cmd.emit_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idle_r      <= apt_pkg::IDLE_TIMEOUT_RST;
      maxp_r      <= apt_pkg::MAX_PERIOD_RST;
    end else begin
      valid_r     <= valid_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          apt_pkg::CFG_IDLE_TIMEOUT: idle_r <= cfg_data;
          apt_pkg::CFG_MAX_PERIOD:   maxp_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_run) begin
      idx_r   <= '0;
      flush_r <= (in_data.opcode == apt_pkg::OP_FLUSH);
      now_r   <= in_data.now_time;
    end else if (cmd.step) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.step && close_hit) begin
      pend_cam_r   <= apt_pkg::CAM_W'(idx_r);
      pend_start_r <= start_rd_r;
      pend_end_r   <= last_rd_r;
    end
    // previous pending period goes out; it is marked last only for emit_last, else another one follows
    if (push_mid || cmd.emit_last) begin
      out_r.period_camera <= pend_cam_r;
      out_r.period_start  <= pend_start_r;
      out_r.period_end    <= pend_end_r;
      out_r.last_of_run   <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/activity_period_timeout_table_unit.sv @@
// Activity period timeout table.
// Input channel (in_valid / in_stall / in_data) takes one transaction per
// accepted edge: activity for a camera, sweep for expired periods, or flush.
// Activity transactions may follow back to back;
// they produce no result.
// A sweep or flush scans all MAX_CAMERAS entries, each in a read state (the
// registered table read) and then an evaluate state, and ends in a closing
// state; in_stall stays high after its accepting edge until the block is idle
// again. The registered table read port is why each entry needs a read state.
// Each closed period leaves as one transaction on out_valid / out_stall /
// out_data; last_of_run marks the final one of a sweep or flush. A closed
// period is held in a pending register and leaves only once the next closed
// period is found or the scan ends.
// While out_stall is high the output register holds; the scan pauses when a
// closed period is found while another is pending and the output register
// is stalled, and the closing cycle waits the same way for the last one.
// Configuration: cfg_valid / cfg_ready, always ready; index 0 is
// idle_timeout, index 1 is max_period. Write only while the block is idle.
// Reset (rst_n low, synchronous) clears the table and output register.
module activity_period_timeout_table_unit #(
  parameter int MAX_CAMERAS = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  apt_pkg::apt_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output apt_pkg::apt_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apt_pkg::TIME_W-1:0]      cfg_data
);

  apt_pkg::apt_cmd_t cmd;
  apt_pkg::apt_sts_t sts;

  assign cfg_ready = 1'b1;

  apt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  apt_dp #(
    .MAX_CAMERAS (MAX_CAMERAS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_run_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     (in_data.opcode == apt_pkg::OP_SWEEP || in_data.opcode == apt_pkg::OP_FLUSH))
    |=> in_stall)
    else $error("input not stalled after sweep or flush start");

  a_activity_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.opcode == apt_pkg::OP_ACTIVITY) |=> !in_stall)
    else $error("activity transaction stalled the input");

  a_emit_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_last |-> (sts.pend_v && sts.out_free))
    else $error("last period emitted without pending entry or free output");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.close_hit && sts.pend_v) |-> sts.out_free)
    else $error("closed period pushed into busy output register");

endmodule
